// ===== hdl/bme_pkg.sv =====
// Shared command, status and state codes for the bitmap engine.
`timescale 1ns / 1ps

package bme_pkg;

  localparam int IDX_W  = 16;
  localparam int LEN_W  = 17;
  localparam int SIZE_W = 17;
  localparam int PROD_W = 2 * LEN_W;
  localparam int CHK_W  = PROD_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;

  typedef enum logic [2:0] {
    CMD_GET          = 3'd0,
    CMD_SET          = 3'd1,
    CMD_CLEAR        = 3'd2,
    CMD_SET_ALL      = 3'd3,
    CMD_CLEAR_ALL    = 3'd4,
    CMD_STRIDE_CLEAR = 3'd5,
    CMD_COPY         = 3'd6,
    CMD_DUPLICATE    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_STRIDE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_RCLR  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CALC  = 5'b00100,
    S_CHECK = 5'b01000,
    S_WALK  = 5'b10000
  } state_e;

endpackage

// ===== hdl/bme_store.sv =====
// Word store with two registered read ports and write-to-read forwarding.
`timescale 1ns / 1ps

module bme_store #(
  parameter int DEPTH = 1024,
  parameter int WB    = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WB-1:0]            wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr_i,
  output logic [WB-1:0]            rd_a_data_o,
  output logic [WB-1:0]            rd_b_data_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WB-1:0] mem [DEPTH];
  logic [WB-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] rd_a_addr_q, rd_b_addr_q;
  logic          fwd_v_q;
  logic [AW-1:0] fwd_addr_q;
  logic [WB-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q      <= mem[rd_a_addr_i];
    rd_b_q      <= mem[rd_b_addr_i];
    rd_a_addr_q <= rd_a_addr_i;
    rd_b_addr_q <= rd_b_addr_i;
    fwd_addr_q  <= wr_addr_i;
    fwd_data_q  <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else begin
      fwd_v_q <= we_i;
    end
  end

  assign rd_a_data_o = (fwd_v_q && fwd_addr_q == rd_a_addr_q) ? fwd_data_q : rd_a_q;
  assign rd_b_data_o = (fwd_v_q && fwd_addr_q == rd_b_addr_q) ? fwd_data_q : rd_b_q;

endmodule

// ===== hdl/bitmap_engine_with_strided_clear.sv =====
// Bitmap engine top level: command decode, range checks, store walker and result stage.
// Get, set, clear: one command per cycle while busy is low; done_o comes through b_q and done_q.
// Set all / clear all: a walk over the store, one word per step, with at least one step.
// Strided clear, copy, duplicate: S_CALC and S_CHECK, then one bit per cycle (cleared positions,
// length, length * (repeat_count - 1)); an empty walk has one step, a flagged one has none.
// Reset clears all MAX_BITS / STORE_WORD_BITS store words with busy high; results are strobes.
`timescale 1ns / 1ps

module bitmap_engine_with_strided_clear #(
  parameter int MAX_BITS        = 65536,
  parameter int STORE_WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [15:0] index_i,
  input  logic [15:0] source_index_i,
  input  logic [15:0] stride_i,
  input  logic [15:0] limit_i,
  input  logic [16:0] length_i,
  input  logic [16:0] repeat_count_i,
  input  logic        bitmap_size_we_i,
  input  logic [16:0] bitmap_size_i,
  output logic        done_o,
  output logic        bit_value_o,
  output logic [1:0]  status_o
);

  localparam int BW    = $clog2(MAX_BITS);
  localparam int WB    = STORE_WORD_BITS;
  localparam int OW    = $clog2(WB);
  localparam int DEPTH = MAX_BITS / STORE_WORD_BITS;
  localparam int WAW   = BW - OW;
  localparam int XW    = ((BW > bme_pkg::IDX_W) ? BW : bme_pkg::IDX_W) + 1;
  localparam int PW    = bme_pkg::PROD_W;
  localparam int CW    = bme_pkg::CHK_W;

  localparam logic [XW-1:0] MAX_X = XW'(MAX_BITS);
  localparam logic [XW-1:0] WB_X  = XW'(STORE_WORD_BITS);

  typedef struct packed {
    logic              res;
    logic              we;
    logic              get;
    logic              use_src;
    logic              fill;
    logic [WB-1:0]     mask;
    logic [OW-1:0]     dst_off;
    logic [OW-1:0]     src_off;
    logic [WAW-1:0]    waddr;
    bme_pkg::status_e  status;
  } tok_t;

  bme_pkg::state_e state_q, state_d;
  bme_pkg::cmd_e   cmd_in, cmd_q;

  logic [bme_pkg::SIZE_W-1:0] size_cfg_q;
  logic [XW-1:0]              size;
  logic [15:0]                idx_q, sidx_q, stride_q, lim_q;
  logic [16:0]                len_q, rep_q;
  logic [PW-1:0]              prod_q;
  logic [XW-1:0]              cur_q, cur_d, src_q, src_d, rem_q, rem_d;
  logic [XW-1:0]              in_pos, fill_left;
  logic [WB-1:0]              fill_mask;
  logic                       accept, cap, walk_have, walk_last;
  logic                       a_valid;
  tok_t                       a_tok;
  logic [WAW-1:0]             a_dst_word, a_src_word;
  logic                       b_valid_q;
  tok_t                       b_q;
  logic [WB-1:0]              dst_w, src_w, wr_data;
  logic                       val_bit, wr_en;
  logic                       done_q, bit_q;
  bme_pkg::status_e           status_q;

  assign accept = start && !busy;
  assign busy   = (state_q != bme_pkg::S_IDLE);
  assign cmd_in = bme_pkg::cmd_e'(command_i);
  assign in_pos = XW'(index_i);
  assign size   = (XW'(size_cfg_q) > MAX_X) ? MAX_X : XW'(size_cfg_q);

  assign fill_left = size - cur_q;
  assign fill_mask = (fill_left >= WB_X) ? {WB{1'b1}}
                                         : ((WB'(1) << fill_left[OW-1:0]) - WB'(1));

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    src_d      = src_q;
    rem_d      = rem_q;
    cap        = 1'b0;
    walk_have  = 1'b0;
    walk_last  = 1'b0;
    a_valid    = 1'b0;
    a_tok      = '0;
    a_dst_word = cur_q[BW-1:OW];
    a_src_word = src_q[BW-1:OW];
    case (state_q)
      bme_pkg::S_RCLR: begin
        a_valid    = 1'b1;
        a_tok.we   = 1'b1;
        a_tok.mask = {WB{1'b1}};
        cur_d      = cur_q + WB_X;
        if (&cur_q[BW-1:OW]) begin
          state_d = bme_pkg::S_IDLE;
        end
      end
      bme_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            bme_pkg::CMD_GET, bme_pkg::CMD_SET, bme_pkg::CMD_CLEAR: begin
              a_valid       = 1'b1;
              a_tok.res     = 1'b1;
              a_dst_word    = in_pos[BW-1:OW];
              a_tok.dst_off = in_pos[OW-1:0];
              if (in_pos >= size) begin
                a_tok.status = bme_pkg::ST_RANGE;
              end else if (cmd_in == bme_pkg::CMD_GET) begin
                a_tok.get = 1'b1;
              end else begin
                a_tok.we   = 1'b1;
                a_tok.mask = WB'(1) << in_pos[OW-1:0];
                a_tok.fill = (cmd_in == bme_pkg::CMD_SET);
              end
            end
            bme_pkg::CMD_SET_ALL, bme_pkg::CMD_CLEAR_ALL: begin
              cap     = 1'b1;
              cur_d   = '0;
              state_d = bme_pkg::S_WALK;
            end
            default: begin
              cap     = 1'b1;
              state_d = bme_pkg::S_CALC;
            end
          endcase
        end
      end
      bme_pkg::S_CALC: begin
        state_d = bme_pkg::S_CHECK;
      end
      bme_pkg::S_CHECK: begin
        state_d = bme_pkg::S_WALK;
        case (cmd_q)
          bme_pkg::CMD_STRIDE_CLEAR: begin
            cur_d = XW'(idx_q);
            if (stride_q == '0) begin
              a_valid      = 1'b1;
              a_tok.res    = 1'b1;
              a_tok.status = bme_pkg::ST_STRIDE;
              state_d      = bme_pkg::S_IDLE;
            end else if (XW'(idx_q) >= size || XW'(lim_q) >= size) begin
              a_valid      = 1'b1;
              a_tok.res    = 1'b1;
              a_tok.status = bme_pkg::ST_RANGE;
              state_d      = bme_pkg::S_IDLE;
            end
          end
          bme_pkg::CMD_COPY: begin
            cur_d = XW'(idx_q);
            src_d = XW'(sidx_q);
            rem_d = XW'(len_q);
            if (CW'(sidx_q) + CW'(len_q) > CW'(size) ||
                CW'(idx_q) + CW'(len_q) > CW'(size)) begin
              a_valid      = 1'b1;
              a_tok.res    = 1'b1;
              a_tok.status = bme_pkg::ST_RANGE;
              state_d      = bme_pkg::S_IDLE;
            end
          end
          default: begin
            cur_d = XW'(idx_q) + XW'(len_q);
            src_d = XW'(idx_q);
            rem_d = (rep_q == '0) ? '0 : XW'(prod_q - PW'(len_q));
            if (CW'(idx_q) + CW'(prod_q) > CW'(size)) begin
              a_valid      = 1'b1;
              a_tok.res    = 1'b1;
              a_tok.status = bme_pkg::ST_RANGE;
              state_d      = bme_pkg::S_IDLE;
            end
          end
        endcase
      end
      bme_pkg::S_WALK: begin
        a_tok.dst_off = cur_q[OW-1:0];
        a_tok.src_off = src_q[OW-1:0];
        case (cmd_q)
          bme_pkg::CMD_SET_ALL, bme_pkg::CMD_CLEAR_ALL: begin
            walk_have  = (cur_q < size);
            walk_last  = (cur_q + WB_X >= size);
            a_tok.mask = fill_mask;
            a_tok.fill = (cmd_q == bme_pkg::CMD_SET_ALL);
            cur_d      = cur_q + WB_X;
          end
          bme_pkg::CMD_STRIDE_CLEAR: begin
            walk_have  = (cur_q <= XW'(lim_q));
            walk_last  = (cur_q + XW'(stride_q) > XW'(lim_q));
            a_tok.mask = WB'(1) << cur_q[OW-1:0];
            cur_d      = cur_q + XW'(stride_q);
          end
          default: begin
            walk_have     = (rem_q != '0);
            walk_last     = (rem_q == XW'(1));
            a_tok.mask    = WB'(1) << cur_q[OW-1:0];
            a_tok.use_src = 1'b1;
            cur_d         = cur_q + XW'(1);
            src_d         = src_q + XW'(1);
            rem_d         = rem_q - XW'(1);
          end
        endcase
        a_valid   = 1'b1;
        a_tok.we  = walk_have;
        a_tok.res = !walk_have || walk_last;
        if (!walk_have || walk_last) begin
          state_d = bme_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bme_pkg::S_IDLE;
      end
    endcase
    a_tok.waddr = a_dst_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bme_pkg::S_RCLR;
      size_cfg_q <= bme_pkg::SIZE_RESET;
      cur_q      <= '0;
      src_q      <= '0;
      rem_q      <= '0;
      b_valid_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      src_q     <= src_d;
      rem_q     <= rem_d;
      b_valid_q <= a_valid;
      done_q    <= b_valid_q && b_q.res;
      if (bitmap_size_we_i) begin
        size_cfg_q <= bitmap_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      cmd_q    <= cmd_in;
      idx_q    <= index_i;
      sidx_q   <= source_index_i;
      stride_q <= stride_i;
      lim_q    <= limit_i;
      len_q    <= length_i;
      rep_q    <= repeat_count_i;
    end
    if (state_q == bme_pkg::S_CALC) begin
      prod_q <= PW'(len_q) * PW'(rep_q);
    end
    b_q      <= a_tok;
    bit_q    <= b_q.get && dst_w[b_q.dst_off];
    status_q <= b_q.status;
  end

  assign val_bit = b_q.use_src ? src_w[b_q.src_off] : b_q.fill;
  assign wr_data = (dst_w & ~b_q.mask) | ({WB{val_bit}} & b_q.mask);
  assign wr_en   = b_valid_q && b_q.we;

  bme_store #(
    .DEPTH (DEPTH),
    .WB    (WB)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (wr_en),
    .wr_addr_i   (b_q.waddr),
    .wr_data_i   (wr_data),
    .rd_a_addr_i (a_dst_word),
    .rd_b_addr_i (a_src_word),
    .rd_a_data_o (dst_w),
    .rd_b_data_o (src_w)
  );

  assign done_o      = done_q;
  assign bit_value_o = bit_q;
  assign status_o    = status_q;

  a_bit_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == bme_pkg::CMD_GET || command_i == bme_pkg::CMD_SET ||
                        command_i == bme_pkg::CMD_CLEAR)) |-> ##2 done_o)
    else $error("single-bit command did not complete in two cycles");

  a_sweep_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bme_pkg::S_RCLR) |-> !(b_valid_q && b_q.res) && !done_o)
    else $error("result beat during reset clearing pass");

  a_walk_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bme_pkg::S_WALK && state_d == bme_pkg::S_IDLE) |-> (a_valid && a_tok.res))
    else $error("walk finished without a result beat");

endmodule
